// ----- src/bcvf_pkg.sv -----
package bcvf_pkg;

    localparam int SLOT_W  = 3;
    localparam int CHAN_W  = 5;
    localparam int VAL_W   = 12;
    localparam int TIME_W  = 14;
    localparam int TUBE_W  = 5;
    localparam int RNG_W   = 5;
    localparam int SCALE_W = 10;
    localparam int VTX_W   = 16;
    localparam int STAT_W  = 2;
    localparam int CIDX_W  = 2;
    localparam int CDAT_W  = 12;
    localparam int PROD_W  = 26;
    localparam int RND_W   = 18;
    localparam int CAL_W   = 11;

    localparam logic [SLOT_W-1:0] SLOT_EAST_SMALL = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_WEST_SMALL = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_LARGE      = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NONE    = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_EAST = 2'd2;
    localparam logic [STAT_W-1:0] ST_NO_WEST = 2'd3;

    localparam logic [CIDX_W-1:0] CFG_ADC_THRESHOLD = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_RANGE_LOW     = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_RANGE_HIGH    = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_SCALE_Q8      = 2'd3;

    localparam logic [VAL_W-1:0]   RST_ADC_THRESHOLD = 12'd10;
    localparam logic [RNG_W-1:0]   RST_RANGE_LOW     = 5'd1;
    localparam logic [RNG_W-1:0]   RST_RANGE_HIGH    = 5'd16;
    localparam logic [SCALE_W-1:0] RST_SCALE_Q8      = 10'd256;

    localparam int CAL_BIAS = 1000;

    localparam logic [TUBE_W-1:0] SMALL_MAP [4][4] = '{
        '{5'd1, 5'd7, 5'd2, 5'd8},
        '{5'd3, 5'd9, 5'd10, 5'd11},
        '{5'd4, 5'd12, 5'd13, 5'd5},
        '{5'd6, 5'd14, 5'd15, 5'd16}
    };
    localparam logic [TUBE_W-1:0] LARGE_MAP [4][4] = '{
        '{5'd17, 5'd18, 5'd19, 5'd20},
        '{5'd21, 5'd22, 5'd23, 5'd24},
        '{5'd17, 5'd18, 5'd19, 5'd20},
        '{5'd21, 5'd22, 5'd23, 5'd24}
    };

    // raw calibration, offset applied is raw minus bias
    localparam logic [CAL_W-1:0] CAL_EAST_RAW [32] = '{
        11'd0, 11'd1555, 11'd1489, 11'd1527, 11'd1536, 11'd1524, 11'd1550, 11'd1512,
        11'd1528, 11'd1507, 11'd1520, 11'd1521, 11'd1533, 11'd1515, 11'd1511, 11'd1537,
        11'd1523, 11'd1042, 11'd984, 11'd953, 11'd1053, 11'd1041, 11'd981, 11'd1034,
        11'd1066, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0
    };
    localparam logic [CAL_W-1:0] CAL_WEST_RAW [32] = '{
        11'd0, 11'd1452, 11'd1518, 11'd1457, 11'd1445, 11'd1454, 11'd1438, 11'd1509,
        11'd1444, 11'd1415, 11'd1462, 11'd1413, 11'd1442, 11'd1460, 11'd1451, 11'd1426,
        11'd1424, 11'd0, 11'd1010, 11'd1321, 11'd976, 11'd1014, 11'd973, 11'd1022,
        11'd872, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0
    };

    typedef struct packed {
        logic              mapped;
        logic              west;
        logic [TUBE_W-1:0] tube;
    } t_map;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_CALC,
        S_FIN
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic wr;
        logic scan_init;
        logic scan_step;
        logic calc;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic in_valid;
        logic in_last;
        logic scan_done;
        logic out_free;
    } t_dp_sts;

    function automatic t_map map_tube(input logic [SLOT_W-1:0] slot,
                                      input logic [CHAN_W-1:0] chan);
        t_map m;
        m.mapped = 1'b1;
        m.west   = 1'b0;
        m.tube   = '0;
        case (slot)
            SLOT_EAST_SMALL: m.tube = SMALL_MAP[chan[4:3]][chan[1:0]];
            SLOT_WEST_SMALL: begin
                m.tube = SMALL_MAP[chan[4:3]][chan[1:0]];
                m.west = 1'b1;
            end
            SLOT_LARGE: begin
                m.tube = LARGE_MAP[chan[4:3]][chan[1:0]];
                m.west = chan[4];
            end
            default: m.mapped = 1'b0;
        endcase
        return m;
    endfunction

endpackage

// ----- src/bcvf_if.sv -----
interface bcvf_in_if import bcvf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] slot;
    logic [CHAN_W-1:0] channel;
    logic [VAL_W-1:0]  reading;
    logic              last;

    modport source (output valid, slot, channel, reading, last, input ready);
    modport sink (input valid, slot, channel, reading, last, output ready);
endinterface

interface bcvf_out_if import bcvf_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VTX_W-1:0] vertex;
    logic [STAT_W-1:0]       status;
    logic [TUBE_W-1:0]       east_count;
    logic [TUBE_W-1:0]       west_count;
    logic [TUBE_W-1:0]       east_latest_tube;
    logic [TUBE_W-1:0]       west_latest_tube;

    modport source (output valid, vertex, status, east_count, west_count,
                    east_latest_tube, west_latest_tube, input ready);
    modport sink (input valid, vertex, status, east_count, west_count,
                  east_latest_tube, west_latest_tube, output ready);
endinterface

interface bcvf_cfg_if import bcvf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CIDX_W-1:0] index;
    logic [CDAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- src/bcvf_ctrl.sv -----
module bcvf_ctrl import bcvf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_sts.in_valid && i_sts.in_last) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: n_state = S_FIN;
            S_FIN: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready  = 1'b1;
                o_cmd.wr        = i_sts.in_valid;
                o_cmd.scan_init = i_sts.in_valid && i_sts.in_last;
            end
            S_SCAN: o_cmd.scan_step = 1'b1;
            S_CALC: o_cmd.calc = 1'b1;
            S_FIN:  o_cmd.load_out = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ----- src/bcvf_dp.sv -----
module bcvf_dp import bcvf_pkg::*; #(
    parameter int TUBES = 25
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bcvf_in_if.sink      i_in,
    bcvf_out_if.source   o_out,
    bcvf_cfg_if.sink     i_cfg,
    input  t_dp_cmd      i_cmd,
    output t_dp_sts      o_sts
);

    localparam int IW = $clog2(TUBES);

    // configuration
    logic [VAL_W-1:0]   r_thr;
    logic [RNG_W-1:0]   r_lo;
    logic [RNG_W-1:0]   r_hi;
    logic [SCALE_W-1:0] r_scale;

    // tube store, side 0 east, side 1 west
    logic [VAL_W-1:0]         r_h  [2][TUBES];
    logic signed [TIME_W-1:0] r_t  [2][TUBES];
    logic [TUBES-1:0]         r_hv [2];
    logic [TUBES-1:0]         r_tv [2];

    // scan, store read registered
    logic [IW-1:0]            r_j;
    logic                     r_rd_en;
    logic [IW-1:0]            r_rd_j;
    logic [VAL_W-1:0]         r_rd_h  [2];
    logic signed [TIME_W-1:0] r_rd_t  [2];
    logic                     r_rd_hv [2];
    logic                     r_rd_tv [2];
    logic [TUBE_W-1:0]        r_cnt  [2];
    logic [TUBE_W-1:0]        r_best [2];
    logic signed [TIME_W-1:0] r_bt   [2];
    logic signed [PROD_W-1:0] r_prod;

    // output word
    logic                    r_ovld;
    logic signed [VTX_W-1:0] r_vtx;
    logic [STAT_W-1:0]       r_stat;
    logic [TUBE_W-1:0]       r_ocnt  [2];
    logic [TUBE_W-1:0]       r_obest [2];

    t_map                     wr_map;
    logic                     wr_hit;
    logic                     wr_side;
    logic [IW-1:0]            wr_idx;
    logic signed [TIME_W-1:0] wr_time;
    logic [CAL_W-1:0]         wr_cal;

    logic [VAL_W-1:0]         sc_h  [2];
    logic signed [TIME_W-1:0] sc_t  [2];
    logic                     sc_q  [2];
    logic [TUBE_W-1:0]        sc_j;

    logic signed [TIME_W:0]   diff;
    logic signed [PROD_W-1:0] n_prod;
    logic [PROD_W-1:0]        mag;
    logic [RND_W-1:0]         rnd;
    logic signed [VTX_W-1:0]  n_vtx;
    logic [STAT_W-1:0]        n_stat;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = i_cmd.in_ready;

    assign o_sts.in_valid  = i_in.valid;
    assign o_sts.in_last   = i_in.last;
    assign o_sts.scan_done = (r_j == IW'(TUBES - 1));
    assign o_sts.out_free  = !r_ovld || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= RST_ADC_THRESHOLD;
            r_lo    <= RST_RANGE_LOW;
            r_hi    <= RST_RANGE_HIGH;
            r_scale <= RST_SCALE_Q8;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_ADC_THRESHOLD: r_thr   <= i_cfg.data[VAL_W-1:0];
                CFG_RANGE_LOW:     r_lo    <= i_cfg.data[RNG_W-1:0];
                CFG_RANGE_HIGH:    r_hi    <= i_cfg.data[RNG_W-1:0];
                CFG_SCALE_Q8:      r_scale <= i_cfg.data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // word routing and time calibration
    always_comb begin
        wr_map  = map_tube(i_in.slot, i_in.channel);
        wr_hit  = wr_map.mapped && ({1'b0, wr_map.tube} < 6'(TUBES));
        wr_side = wr_map.west;
        wr_idx  = wr_map.tube[IW-1:0];
        wr_cal  = wr_map.west ? CAL_WEST_RAW[wr_map.tube] : CAL_EAST_RAW[wr_map.tube];
        wr_time = $signed({2'b00, i_in.reading}) + TIME_W'(CAL_BIAS)
                  - $signed({3'b000, wr_cal});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && wr_hit) begin
            if (!i_in.channel[2]) begin
                r_h[wr_side][wr_idx] <= i_in.reading;
            end else begin
                r_t[wr_side][wr_idx] <= wr_time;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load_out) begin
            r_hv[0] <= '0;
            r_hv[1] <= '0;
            r_tv[0] <= '0;
            r_tv[1] <= '0;
        end else if (i_cmd.wr && wr_hit) begin
            if (!i_in.channel[2]) begin
                r_hv[wr_side][wr_idx] <= 1'b1;
            end else begin
                r_tv[wr_side][wr_idx] <= 1'b1;
            end
        end
    end

    // one tube per side per cycle
    always_ff @(posedge i_clk) begin
        r_rd_j <= r_j;
        for (int s = 0; s < 2; s++) begin
            r_rd_h[s]  <= r_h[s][r_j];
            r_rd_t[s]  <= r_t[s][r_j];
            r_rd_hv[s] <= r_hv[s][r_j];
            r_rd_tv[s] <= r_tv[s][r_j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_en <= 1'b0;
        end else begin
            r_rd_en <= i_cmd.scan_step && !o_sts.scan_done;
        end
    end

    always_comb begin
        sc_j = TUBE_W'(r_rd_j);
        for (int s = 0; s < 2; s++) begin
            sc_h[s] = r_rd_hv[s] ? r_rd_h[s] : '0;
            sc_t[s] = r_rd_tv[s] ? r_rd_t[s] : '0;
            sc_q[s] = (sc_h[s] > r_thr) && (sc_j >= r_lo) && (sc_j <= r_hi)
                      && (sc_t[s] > 0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.scan_init) begin
            r_j <= '0;
        end else if (i_cmd.scan_step && !o_sts.scan_done) begin
            r_j <= r_j + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < 2; s++) begin
            if (i_cmd.scan_init) begin
                r_cnt[s]  <= '0;
                r_best[s] <= '0;
                r_bt[s]   <= '0;
            end else if (r_rd_en && sc_q[s]) begin
                if (r_cnt[s] == '0 || sc_t[s] > r_bt[s]) begin
                    r_best[s] <= sc_j;
                    r_bt[s]   <= sc_t[s];
                end
                r_cnt[s] <= r_cnt[s] + 1'b1;
            end
        end
    end

    always_comb begin
        diff   = (TIME_W+1)'(r_bt[0]) - (TIME_W+1)'(r_bt[1]);
        n_prod = PROD_W'(diff) * PROD_W'($signed({1'b0, r_scale}));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_prod <= n_prod;
        end
    end

    // round half away from zero, then saturate; vertex is zero unless status is ok
    always_comb begin
        mag = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);
        rnd = RND_W'((mag + PROD_W'(128)) >> 8);
        if (r_prod[PROD_W-1]) begin
            n_vtx = (rnd > RND_W'(32768)) ? 16'sh8000 : VTX_W'(-rnd);
        end else begin
            n_vtx = (rnd > RND_W'(32767)) ? 16'sh7fff : $signed(rnd[VTX_W-1:0]);
        end
        if (r_cnt[0] == '0 && r_cnt[1] == '0) begin
            n_stat = ST_NONE;
        end else if (r_cnt[0] == '0) begin
            n_stat = ST_NO_EAST;
        end else if (r_cnt[1] == '0) begin
            n_stat = ST_NO_WEST;
        end else begin
            n_stat = ST_OK;
        end
        if (n_stat != ST_OK) begin
            n_vtx = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_ovld <= 1'b1;
        end else if (o_out.ready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_vtx      <= n_vtx;
            r_stat     <= n_stat;
            r_ocnt[0]  <= r_cnt[0];
            r_ocnt[1]  <= r_cnt[1];
            r_obest[0] <= r_best[0];
            r_obest[1] <= r_best[1];
        end
    end

    assign o_out.valid            = r_ovld;
    assign o_out.vertex           = r_vtx;
    assign o_out.status           = r_stat;
    assign o_out.east_count       = r_ocnt[0];
    assign o_out.west_count       = r_ocnt[1];
    assign o_out.east_latest_tube = r_obest[0];
    assign o_out.west_latest_tube = r_obest[1];

endmodule

// ----- src/beam_counter_vertex_finder.sv -----
// channel  | dir | fields                                           | takes
// i_in     | in  | slot, channel, reading, last                     | one reading per word
// o_out    | out | vertex, status, east/west count, east/west tube  | one word per event
// i_cfg    | in  | index, data                                      | always ready
//
// a reading without last is written to the tube store; the block stays ready for the next
// a last reading starts the scan: a registered store read, one tube per side per
// cycle over TUBES-1 tubes, then a multiply state and an output state that waits
// until the output register is free
// the output register holds a word until taken; the next event waits for it
// readings are taken while a finished word waits
// synchronous active-low reset clears the tube store valid flags and restores the config registers
module beam_counter_vertex_finder import bcvf_pkg::*; #(
    parameter int TUBES = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bcvf_in_if.sink     i_in,
    bcvf_out_if.source  o_out,
    bcvf_cfg_if.sink    i_cfg
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    bcvf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    bcvf_dp #(
        .TUBES (TUBES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cfg   (i_cfg),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );

endmodule

// ----- src/bcvf_checker.sv -----
module bcvf_checker import bcvf_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    i_in_ready,
    input logic                    i_in_last,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic signed [VTX_W-1:0] i_vertex,
    input logic [STAT_W-1:0]       i_status,
    input logic [TUBE_W-1:0]       i_east_count,
    input logic [TUBE_W-1:0]       i_west_count,
    input logic [TUBE_W-1:0]       i_east_latest_tube,
    input logic [TUBE_W-1:0]       i_west_latest_tube
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_vertex)
        && $stable(i_status))
        else $error("output word changed while stalled");

    a_vertex_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ST_OK |-> i_vertex == '0)
        else $error("vertex nonzero without ok status");

    a_status_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_status == ST_NONE) == (i_east_count == '0 && i_west_count == '0))
        && ((i_status == ST_NO_EAST) == (i_east_count == '0 && i_west_count != '0))
        && ((i_status == ST_NO_WEST) == (i_east_count != '0 && i_west_count == '0)))
        else $error("status disagrees with counts");

    a_empty_tube: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_east_count != '0 || i_east_latest_tube == '0)
        && (i_west_count != '0 || i_west_latest_tube == '0))
        else $error("latest tube set on a side with no hit");

    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_last |=> !i_in_ready)
        else $error("reading taken during event scan");

endmodule

bind beam_counter_vertex_finder bcvf_checker u_bcvf_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in.valid),
    .i_in_ready         (i_in.ready),
    .i_in_last          (i_in.last),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_vertex           (o_out.vertex),
    .i_status           (o_out.status),
    .i_east_count       (o_out.east_count),
    .i_west_count       (o_out.west_count),
    .i_east_latest_tube (o_out.east_latest_tube),
    .i_west_latest_tube (o_out.west_latest_tube)
);
